>>> hdl/mie_pkg.sv
`default_nettype none
package mie_pkg;

  // Payload width of the channels; the arithmetic uses only the low WIDTH bits.
  localparam int DATA_W = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_DIV,
    ST_UPDATE,
    ST_FIX,
    ST_NEG,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> hdl/mie_in_if.sv
`default_nettype none
interface mie_in_if;
  import mie_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;
  logic [DATA_W-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface
`default_nettype wire

>>> hdl/mie_out_if.sv
`default_nettype none
interface mie_out_if;
  import mie_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] inverse;
  logic              has_inverse;

  modport source (output valid, output inverse, output has_inverse, input ready);
  modport sink   (input valid, input inverse, input has_inverse, output ready);
endinterface
`default_nettype wire

>>> hdl/modular_inverse_ext_euclid.sv
// Modular inverse by the extended Euclidean algorithm. A beat on req carries a value and a
// modulus (only the low WIDTH bits count); one beat on rsp later returns the inverse in
// 0..modulus-1 with has_inverse set, or 0 with has_inverse clear when the gcd is not 1 or the
// modulus is below two. One item is worked at a time and req is not ready until its result
// beat has been taken. Every Euclid step is a shift-and-subtract division on one shared
// subtractor: the divisor is first shifted up to the dividend one position at a time, then
// one quotient bit is produced per cycle while the coefficient update accumulates on one
// shared adder, and the UPDATE state rotates the registers. The result beat is held
// until rsp.ready; a modulus below two skips the Euclid steps and goes to the result beat.
`default_nettype none
module modular_inverse_ext_euclid #(
  parameter int WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  mie_in_if.sink     req,
  mie_out_if.source  rsp
);
  import mie_pkg::*;

  localparam int KW = $clog2(WIDTH);

  state_t state, state_next;

  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] cur_r;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dsh;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] prev_mag;
  logic [WIDTH-1:0] cur_mag;
  logic [WIDTH-1:0] res_inv;
  logic [KW-1:0]    k;
  logic             prev_neg;
  logic             gcd_one;
  logic             res_ok;

  logic [WIDTH-1:0] in_a;
  logic [WIDTH-1:0] in_m;
  logic             in_m_small;
  logic             fits;

  logic [WIDTH-1:0] sub_x, sub_y, add_x, add_y, diff, sum;
  logic             borrow;

  assign in_a       = req.value[WIDTH-1:0];
  assign in_m       = req.modulus[WIDTH-1:0];
  assign in_m_small = (in_m[WIDTH-1:1] == '0);

  mie_alu #(.WIDTH(WIDTH)) u_alu (
    .sub_x  (sub_x),
    .sub_y  (sub_y),
    .add_x  (add_x),
    .add_y  (add_y),
    .diff   (diff),
    .borrow (borrow),
    .sum    (sum)
  );

  // The divisor may move up one more place while it stays in range and not above the dividend.
  assign fits = !dsh[WIDTH-1] && !borrow;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = in_m_small ? ST_DONE : ST_ALIGN;
        end
      end
      ST_ALIGN:  state_next = fits ? ST_ALIGN : ST_DIV;
      ST_DIV:    state_next = (k == '0) ? ST_UPDATE : ST_DIV;
      ST_UPDATE: state_next = (rem == '0) ? ST_FIX : ST_ALIGN;
      ST_FIX:    state_next = ST_NEG;
      ST_NEG:    state_next = ST_DONE;
      ST_DONE: begin
        if (rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sub_x     = rem;
    sub_y     = dsh;
    add_x     = {acc[WIDTH-2:0], 1'b0};
    add_y     = cur_mag;
    req.ready = 1'b0;
    rsp.valid = 1'b0;
    case (state)
      ST_IDLE:   req.ready = 1'b1;
      ST_ALIGN:  sub_y = {dsh[WIDTH-2:0], 1'b0};
      ST_UPDATE: begin
        add_x = prev_mag;
        add_y = acc;
      end
      ST_FIX: begin
        sub_x = prev_mag;
        sub_y = m;
      end
      ST_NEG: begin
        sub_x = m;
        sub_y = rem;
      end
      ST_DONE:   rsp.valid = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          m        <= in_m;
          rem      <= in_a;
          cur_r    <= in_m;
          dsh      <= in_m;
          k        <= '0;
          acc      <= '0;
          prev_mag <= WIDTH'(1);
          cur_mag  <= '0;
          prev_neg <= 1'b0;
          gcd_one  <= 1'b0;
          res_inv  <= '0;
          res_ok   <= 1'b0;
        end
      end
      ST_ALIGN: begin
        if (fits) begin
          dsh <= {dsh[WIDTH-2:0], 1'b0};
          k   <= k + KW'(1);
        end
      end
      ST_DIV: begin
        if (!borrow) begin
          rem <= diff;
          acc <= sum;
        end else begin
          acc <= {acc[WIDTH-2:0], 1'b0};
        end
        dsh <= {1'b0, dsh[WIDTH-1:1]};
        k   <= k - KW'(1);
      end
      ST_UPDATE: begin
        prev_mag <= cur_mag;
        cur_mag  <= sum;
        prev_neg <= !prev_neg;
        cur_r    <= rem;
        rem      <= cur_r;
        dsh      <= rem;
        k        <= '0;
        acc      <= '0;
        gcd_one  <= (cur_r == WIDTH'(1));
      end
      ST_FIX: begin
        // The final coefficient never exceeds the modulus, so one subtract reduces it.
        rem <= borrow ? prev_mag : diff;
      end
      ST_NEG: begin
        res_ok <= gcd_one;
        if (!gcd_one) begin
          res_inv <= '0;
        end else if (prev_neg && rem != '0) begin
          res_inv <= diff;
        end else begin
          res_inv <= rem;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.inverse     = DATA_W'(res_inv);
  assign rsp.has_inverse = res_ok;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("input taken while a result is pending");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALIGN || state == ST_DIV) |-> cur_r != '0)
    else $error("division started with a zero divisor");

  a_inverse_in_range: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && res_ok) |-> res_inv < m)
    else $error("inverse not below the modulus");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("ready stayed high after an accepted beat");

endmodule
`default_nettype wire

>>> hdl/mie_alu.sv
`default_nettype none
module mie_alu #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] sub_x,
  input  logic [WIDTH-1:0] sub_y,
  input  logic [WIDTH-1:0] add_x,
  input  logic [WIDTH-1:0] add_y,
  output logic [WIDTH-1:0] diff,
  output logic             borrow,
  output logic [WIDTH-1:0] sum
);
  logic [WIDTH:0] sub_full;

  // The borrow doubles as the compare: it is clear exactly when sub_x >= sub_y.
  assign sub_full = {1'b0, sub_x} - {1'b0, sub_y};
  assign diff     = sub_full[WIDTH-1:0];
  assign borrow   = sub_full[WIDTH];
  assign sum      = add_x + add_y;
endmodule
`default_nettype wire
